// ===== sv/xcr_pkg.sv =====
`default_nettype none

package xcr_pkg;

   localparam int BLOCK_BYTES = 128;
   localparam int ADDR_BITS   = 16;
   localparam int WORDS       = BLOCK_BYTES / 8;
   localparam int WORD_BITS   = $clog2(WORDS);
   localparam int FRAME_LEN   = BLOCK_BYTES + 3;

   localparam logic [7:0] SOH_BYTE = 8'h01;
   localparam logic [7:0] EOT_BYTE = 8'h04;
   localparam logic [7:0] ACK_BYTE = 8'h06;
   localparam logic [7:0] NAK_BYTE = 8'h15;

   localparam logic [7:0] FAIL_MAX        = 8'hFF;
   localparam logic [7:0] MAX_ERRORS_INIT = 8'd25;

   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_BYTE    = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;
   localparam logic [1:0] CMD_QUIET   = 2'd3;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_ABORT = 2'd2;

   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   localparam logic REG_DEST_BASE  = 1'b0;
   localparam logic REG_MAX_ERRORS = 1'b1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic                 kind;
      logic [7:0]           reply_byte;
      logic [63:0]          data_word;
      logic [ADDR_BITS-1:0] word_address;
      logic [1:0]           status;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic                 wr_byte;
      logic [7:0]           data;
      logic [WORD_BITS-1:0] word_idx;
      logic [2:0]           byte_sel;
      logic                 rd_en;
      logic [WORD_BITS-1:0] rd_idx;
   } buf_ctl_type;

endpackage

`default_nettype wire

// ===== sv/xcr_frame_buf.sv =====
`default_nettype none

module xcr_frame_buf (
   input  wire logic                clock,
   input  wire xcr_pkg::buf_ctl_type ctl,
   output logic [63:0]              rd_data
);
   import xcr_pkg::*;

   logic [63:0] mem [WORDS];
   logic [55:0] asm_ff;
   logic [63:0] rd_data_ff;

   // bytes 0..6 of a word collect in asm_ff, byte 7 commits the word
   always_ff @(posedge clock) begin
      if (ctl.wr_byte) begin
         if (ctl.byte_sel == 3'd7) begin
            mem[ctl.word_idx] <= {ctl.data, asm_ff};
         end else begin
            asm_ff[ctl.byte_sel*8 +: 8] <= ctl.data;
         end
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/xmodem_checksum_receiver.sv =====
`default_nettype none
// XMODEM receiver, 128-byte blocks with 8-bit additive checksum.
// req channel: one event word per accept (start, line byte, long timeout, line quiet).
// rsp channel: reply bytes (ACK/NAK with status) and 64-bit data word writes.
// csr port: index 0 dest_base, index 1 max_errors; write only while idle.
// An event that produces a result presents it in the rsp register the cycle after
// accept. Most events finish at accept and the next can follow at once.
// The checksum byte of a good new block starts a drain: the 16 data words are read
// back from the frame buffer, each through the buffer's read register and then the
// rsp register load, followed by the ACK, with req_stall high throughout the drain.
// Each word needs rsp to be free, so rsp_stall lengthens the drain.
// req_stall is also high while a result sits in the rsp register and rsp_stall holds.
// Reset: synchronous; the receiver is stopped (waits for a start event), dest_base 0,
// max_errors 25, expected block 1. Buffer contents are not cleared.
module xmodem_checksum_receiver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire xcr_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output xcr_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_we,
   input  wire logic                            csr_index,
   input  wire logic [xcr_pkg::ADDR_BITS-1:0]   csr_wdata
);
   import xcr_pkg::*;

   localparam logic [2:0] PH_STOPPED   = 3'd0;
   localparam logic [2:0] PH_WAIT      = 3'd1;
   localparam logic [2:0] PH_FRAME     = 3'd2;
   localparam logic [2:0] PH_DISCARD   = 3'd3;
   localparam logic [2:0] PH_DRAIN_RD  = 3'd4;
   localparam logic [2:0] PH_DRAIN_LD  = 3'd5;
   localparam logic [2:0] PH_DRAIN_ACK = 3'd6;

   localparam logic [7:0] LAST_IDX = 8'(FRAME_LEN - 1);

   logic [ADDR_BITS-1:0] dest_base_ff;
   logic [7:0]           max_errors_ff;

   logic [2:0]           phase_ff, phase_in;
   logic [7:0]           expected_ff, expected_in;
   logic [8:0]           stored_ff, stored_in;
   logic [7:0]           fail_ff, fail_in;
   logic [7:0]           index_ff, index_in;
   logic [7:0]           blk_num_ff, blk_num_in;
   logic [7:0]           blk_cmp_ff, blk_cmp_in;
   logic [7:0]           sum_ff, sum_in;
   logic [7:0]           pend_reply_ff, pend_reply_in;
   logic                 pend_abort_ff, pend_abort_in;
   logic [WORD_BITS-1:0] drain_k_ff, drain_k_in;
   logic [ADDR_BITS-1:0] drain_base_ff, drain_base_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   buf_ctl_type          buf_ctl;
   logic [63:0]          buf_rd_data;

   logic                 out_free;
   logic                 drain_busy;
   logic                 accept;
   logic [7:0]           fail_inc;
   logic                 fail_abort;
   logic [7:0]           data_off;
   logic [7:0]           prev_block;

   xcr_frame_buf u_buf (
      .clock   (clock),
      .ctl     (buf_ctl),
      .rd_data (buf_rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign drain_busy = (phase_ff == PH_DRAIN_RD) || (phase_ff == PH_DRAIN_LD) ||
                       (phase_ff == PH_DRAIN_ACK);
   assign req_stall  = drain_busy || !out_free;
   assign accept     = req_valid && !req_stall;

   assign fail_inc   = (fail_ff == FAIL_MAX) ? FAIL_MAX : fail_ff + 8'd1;
   assign fail_abort = fail_inc >= max_errors_ff;
   assign data_off   = index_ff - 8'd2;
   assign prev_block = expected_ff - 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      expected_in   = expected_ff;
      stored_in     = stored_ff;
      fail_in       = fail_ff;
      index_in      = index_ff;
      blk_num_in    = blk_num_ff;
      blk_cmp_in    = blk_cmp_ff;
      sum_in        = sum_ff;
      pend_reply_in = pend_reply_ff;
      pend_abort_in = pend_abort_ff;
      drain_k_in    = drain_k_ff;
      drain_base_in = drain_base_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      buf_ctl          = '0;
      buf_ctl.data     = req_data.rx_byte;
      buf_ctl.word_idx = data_off[WORD_BITS+2:3];
      buf_ctl.byte_sel = data_off[2:0];
      buf_ctl.rd_idx   = drain_k_ff;

      if (accept) begin
         rsp_in            = '0;
         rsp_in.kind       = KIND_REPLY;
         rsp_in.last       = 1'b1;
         if (req_data.cmd == CMD_START) begin
            expected_in   = 8'd1;
            stored_in     = '0;
            fail_in       = '0;
            index_in      = '0;
            pend_reply_in = '0;
            pend_abort_in = 1'b0;
            phase_in      = PH_WAIT;
            rsp_valid_in  = 1'b1;
            rsp_in.reply_byte = NAK_BYTE;
            rsp_in.status     = ST_RUN;
         end else begin
            case (phase_ff)
               PH_WAIT: begin
                  if (req_data.cmd == CMD_BYTE) begin
                     if (req_data.rx_byte == SOH_BYTE) begin
                        index_in = '0;
                        sum_in   = '0;
                        phase_in = PH_FRAME;
                     end else if (req_data.rx_byte == EOT_BYTE) begin
                        phase_in          = PH_STOPPED;
                        rsp_valid_in      = 1'b1;
                        rsp_in.reply_byte = ACK_BYTE;
                        rsp_in.status     = ST_DONE;
                     end else begin
                        fail_in       = fail_inc;
                        pend_reply_in = NAK_BYTE;
                        pend_abort_in = fail_abort;
                        phase_in      = PH_DISCARD;
                     end
                  end else if (req_data.cmd == CMD_TIMEOUT) begin
                     fail_in           = fail_inc;
                     phase_in          = fail_abort ? PH_STOPPED : PH_WAIT;
                     rsp_valid_in      = 1'b1;
                     rsp_in.reply_byte = NAK_BYTE;
                     rsp_in.status     = fail_abort ? ST_ABORT : ST_RUN;
                  end
               end
               PH_FRAME: begin
                  if (req_data.cmd == CMD_BYTE) begin
                     index_in = index_ff + 8'd1;
                     if (index_ff == 8'd0) begin
                        blk_num_in = req_data.rx_byte;
                     end else if (index_ff == 8'd1) begin
                        blk_cmp_in = req_data.rx_byte;
                     end else if (index_ff < LAST_IDX) begin
                        buf_ctl.wr_byte = 1'b1;
                        sum_in          = sum_ff + req_data.rx_byte;
                     end else begin
                        index_in = '0;
                        if (blk_cmp_ff != ~blk_num_ff) begin
                           fail_in       = fail_inc;
                           pend_reply_in = NAK_BYTE;
                           pend_abort_in = fail_abort;
                           phase_in      = PH_DISCARD;
                        end else if (blk_num_ff == prev_block) begin
                           fail_in       = '0;
                           pend_reply_in = ACK_BYTE;
                           pend_abort_in = 1'b0;
                           phase_in      = PH_DISCARD;
                        end else if (blk_num_ff == expected_ff &&
                                     sum_ff == req_data.rx_byte) begin
                           drain_base_in = dest_base_ff + ADDR_BITS'({stored_ff, 7'b0});
                           drain_k_in    = '0;
                           expected_in   = expected_ff + 8'd1;
                           stored_in     = stored_ff + 9'd1;
                           fail_in       = '0;
                           phase_in      = PH_DRAIN_RD;
                        end else begin
                           fail_in       = fail_inc;
                           pend_reply_in = NAK_BYTE;
                           pend_abort_in = fail_abort;
                           phase_in      = PH_DISCARD;
                        end
                     end
                  end else if (req_data.cmd == CMD_TIMEOUT) begin
                     index_in      = '0;
                     fail_in       = fail_inc;
                     pend_reply_in = NAK_BYTE;
                     pend_abort_in = fail_abort;
                     phase_in      = PH_DISCARD;
                  end
               end
               PH_DISCARD: begin
                  if (req_data.cmd == CMD_TIMEOUT || req_data.cmd == CMD_QUIET) begin
                     rsp_valid_in      = 1'b1;
                     rsp_in.reply_byte = pend_reply_ff;
                     rsp_in.status     = pend_abort_ff ? ST_ABORT : ST_RUN;
                     phase_in          = pend_abort_ff ? PH_STOPPED : PH_WAIT;
                     pend_reply_in     = '0;
                     pend_abort_in     = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
      end else begin
         case (phase_ff)
            PH_DRAIN_RD: begin
               buf_ctl.rd_en = 1'b1;
               phase_in      = PH_DRAIN_LD;
            end
            PH_DRAIN_LD: begin
               if (out_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in              = '0;
                  rsp_in.kind         = KIND_DATA;
                  rsp_in.data_word    = buf_rd_data;
                  rsp_in.word_address = drain_base_ff +
                                        ADDR_BITS'({drain_k_ff, 3'b0});
                  drain_k_in          = drain_k_ff + WORD_BITS'(1);
                  phase_in = (drain_k_ff == WORD_BITS'(WORDS - 1)) ? PH_DRAIN_ACK
                                                                  : PH_DRAIN_RD;
               end
            end
            PH_DRAIN_ACK: begin
               if (out_free) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in            = '0;
                  rsp_in.kind       = KIND_REPLY;
                  rsp_in.reply_byte = ACK_BYTE;
                  rsp_in.status     = ST_RUN;
                  rsp_in.last       = 1'b1;
                  phase_in          = PH_WAIT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_base_ff  <= '0;
         max_errors_ff <= MAX_ERRORS_INIT;
         phase_ff      <= PH_STOPPED;
         expected_ff   <= 8'd1;
         stored_ff     <= '0;
         fail_ff       <= '0;
         index_ff      <= '0;
         sum_ff        <= '0;
         pend_reply_ff <= '0;
         pend_abort_ff <= 1'b0;
         drain_k_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we && csr_index == REG_DEST_BASE) begin
            dest_base_ff <= csr_wdata;
         end
         if (csr_we && csr_index == REG_MAX_ERRORS) begin
            max_errors_ff <= csr_wdata[7:0];
         end
         phase_ff      <= phase_in;
         expected_ff   <= expected_in;
         stored_ff     <= stored_in;
         fail_ff       <= fail_in;
         index_ff      <= index_in;
         sum_ff        <= sum_in;
         pend_reply_ff <= pend_reply_in;
         pend_abort_ff <= pend_abort_in;
         drain_k_ff    <= drain_k_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_num_ff    <= blk_num_in;
      blk_cmp_ff    <= blk_cmp_in;
      drain_base_ff <= drain_base_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_accept_in_drain: assert property (@(posedge clock) disable iff (reset)
      drain_busy |-> req_stall)
      else $error("event accepted during block drain");

   a_ack_ends_drain: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DRAIN_ACK && out_free |=>
         rsp_valid_ff && rsp_ff.last && rsp_ff.reply_byte == ACK_BYTE)
      else $error("drain did not end with ACK");

   a_data_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_DATA |-> !rsp_ff.last)
      else $error("data word marked last");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FRAME |-> index_ff <= LAST_IDX)
      else $error("frame index past frame length");

endmodule

`default_nettype wire
